>>> src/cfrq_pkg.sv
//------------------------------------------------------------------------------
// cfrq_pkg: shared types and constants
// Sizes, codes, state encoding and the command and status groups used
// between the controller and the datapath of the reassembly queue.
//------------------------------------------------------------------------------
`default_nettype none
package cfrq_pkg;
    localparam int QUEUE_DEPTH  = 16;
    localparam int FILTER_SLOTS = 16;
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(FILTER_SLOTS);
    localparam int MAX_OUT = 16;
    localparam int OW = $clog2(MAX_OUT + 1);

    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [1:0] TYPE_MIDDLE = 2'd0;
    localparam logic [1:0] TYPE_START  = 2'd1;
    localparam logic [1:0] TYPE_STOP   = 2'd2;
    localparam logic [1:0] TYPE_SMALL  = 2'd3;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_FILTERED = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_CHUNK    = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE, S_FSCAN, S_FDEC, S_REL, S_SKIP,
        S_FIND, S_DELIV, S_SMALL, S_CLEAR
    } state_t;

    typedef struct packed {
        logic       cap;        // capture input item
        logic       fscan;      // step filter slot scan
        logic       frame_dec;  // decide frame outcome
        logic       rel_step;   // release scan step
        logic       skip_step;  // advance consume over stale entry
        logic       find_step;  // search step
        logic       deliv_step; // delivery walk step
        logic       small_out;  // emit small packet
        logic       clr_step;   // clear sweep step
        logic       emit_empty; // emit nothing to read
        logic       emit_zero;  // emit zero chunk when nothing delivered
        logic       emit_clear; // emit clear acknowledge
        logic       deliv_init; // reset walk to consume pointer
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       fscan_done;
        logic       frame_to_rel;
        logic       rel_done;
        logic       skip_done;
        logic       find_done;
        logic       find_small;
        logic       find_stop;
        logic       deliv_done;
        logic       deliv_any;
        logic       clr_done;
    } sts_t;
endpackage
`default_nettype wire

>>> src/cfrq_ctrl.sv
//------------------------------------------------------------------------------
// cfrq_ctrl: sequencing state machine
// Steps each command through scans of the filter table and the ring.
//------------------------------------------------------------------------------
`default_nettype none
module cfrq_ctrl
    import cfrq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output ctl_t      ctl,
    input  sts_t      sts
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_FSCAN;
            S_FSCAN:
            begin
                case (sts.cmd)
                    CMD_FRAME: if (sts.fscan_done) state_next = S_FDEC;
                    CMD_READ:  state_next = S_FIND;
                    CMD_CLEAR: state_next = S_CLEAR;
                    default:   state_next = S_IDLE;
                endcase
            end
            S_FDEC:  state_next = sts.frame_to_rel ? S_REL : S_IDLE;
            S_REL:   if (sts.rel_done) state_next = S_SKIP;
            S_SKIP:  if (sts.skip_done) state_next = S_IDLE;
            S_FIND:
            begin
                if (sts.find_small)
                    state_next = S_SMALL;
                else if (sts.find_stop)
                    state_next = S_DELIV;
                else if (sts.find_done)
                    state_next = S_IDLE;
            end
            S_SMALL: state_next = S_SKIP;
            S_DELIV: if (sts.deliv_done) state_next = S_SKIP;
            S_CLEAR: if (sts.clr_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        busy = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:  ctl.cap = start;
            S_FSCAN:
            begin
                ctl.fscan = (sts.cmd == CMD_FRAME);
                ctl.deliv_init = 1'b1;
            end
            S_FDEC:  ctl.frame_dec = 1'b1;
            S_REL:   ctl.rel_step = 1'b1;
            S_SKIP:  ctl.skip_step = 1'b1;
            S_FIND:
            begin
                ctl.find_step = 1'b1;
                ctl.emit_empty = sts.find_done && !sts.find_small && !sts.find_stop;
            end
            S_SMALL: ctl.small_out = 1'b1;
            S_DELIV:
            begin
                ctl.deliv_step = 1'b1;
                ctl.emit_zero = sts.deliv_done && !sts.deliv_any;
            end
            S_CLEAR:
            begin
                ctl.clr_step = 1'b1;
                ctl.emit_clear = sts.clr_done;
            end
            default: ctl = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> src/cfrq_dp.sv
//------------------------------------------------------------------------------
// cfrq_dp: queue datapath
// Ring store, filter table, pointers, scan cursors and result register.
//------------------------------------------------------------------------------
`default_nettype none
module cfrq_dp
    import cfrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [1:0]  command,
    input  wire logic [1:0]  frame_type,
    input  wire logic [7:0]  frame_source,
    input  wire logic [3:0]  frame_length,
    input  wire logic [63:0] frame_payload,
    input  wire logic        filter_drop,
    input  wire logic [9:0]  read_limit,
    input  ctl_t             ctl,
    output sts_t             sts,
    output logic             done,
    output logic [2:0]       status,
    output logic [7:0]       packet_source,
    output logic [63:0]      chunk_data,
    output logic [3:0]       chunk_count,
    output logic             last
);
    // Entry payloads live in a memory; metadata and used bits in flops.
    logic [63:0]      pay_mem [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] used_reg;
    logic [1:0]       mtype [QUEUE_DEPTH];
    logic [7:0]       msrc  [QUEUE_DEPTH];
    logic [3:0]       mlen  [QUEUE_DEPTH];
    logic [8:0]       fslot_reg [FILTER_SLOTS];

    logic [QW-1:0] ins_reg, con_reg, cur_reg, stop_reg;
    logic [QW:0]   cnt_reg;
    logic [FW:0]   fidx_reg;
    logic          fhit_reg, ffree_reg;
    logic [FW-1:0] fpos_reg;
    logic [1:0]  cmd_reg, typ_reg;
    logic [7:0]  src_reg;
    logic [3:0]  len_reg;
    logic [63:0] pay_reg;
    logic        drop_reg;
    logic [9:0]  lim_reg;
    logic [10:0] pos_reg;
    logic [OW-1:0] n_reg;
    logic [QW-1:0] small_reg;
    logic        walk_end_reg;

    logic [2:0]  st_reg;
    logic [7:0]  ps_reg;
    logic [63:0] cd_reg;
    logic [3:0]  cc_reg;
    logic        last_reg, done_reg;
    logic [63:0] rd_reg;

    function automatic logic [63:0] bmask(input logic [3:0] c);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++)
            if (4'(b) < c) m[b*8 +: 8] = 8'hff;
        return m;
    endfunction

    logic [QW-1:0] cur_nx;
    logic [QW-1:0] fpos_cur;
    assign cur_nx = cur_reg + 1'b1;
    assign fpos_cur = fidx_reg[FW-1:0];

    // Filter decision helpers
    logic filt_hit;
    assign filt_hit = (typ_reg == TYPE_SMALL && drop_reg) ||
                      (typ_reg == TYPE_START && drop_reg && ffree_reg) ||
                      ((typ_reg == TYPE_MIDDLE || typ_reg == TYPE_STOP) && fhit_reg);
    logic full;
    assign full = (ins_reg + 1'b1 == con_reg);

    logic [10:0] rem;
    logic [3:0]  cchunk;
    logic        chunk_last;
    assign rem = {1'b0, lim_reg} - pos_reg;
    assign cchunk = ({7'd0, mlen[cur_reg]} > rem) ? rem[3:0] : mlen[cur_reg];
    // A chunk is the final one when the walk ends on it, when it reaches the
    // byte limit, or when it is the last chunk slot.
    assign chunk_last = sts.deliv_done ||
                        (pos_reg + {7'd0, cchunk} >= {1'b0, lim_reg}) ||
                        (n_reg == OW'(MAX_OUT - 1));

    always_comb
    begin
        sts = '0;
        sts.cmd = cmd_reg;
        sts.fscan_done = fidx_reg[FW] ||
            ((typ_reg == TYPE_START) && ffree_reg) ||
            ((typ_reg != TYPE_START) && fhit_reg) ||
            (typ_reg == TYPE_SMALL);
        sts.frame_to_rel = !filt_hit && full && typ_reg == TYPE_STOP;
        sts.rel_done = (cur_reg == ins_reg) || (cur_nx == ins_reg);
        sts.skip_done = (con_reg == ins_reg) || used_reg[con_reg];
        sts.find_done = (cur_reg == ins_reg);
        sts.find_small = !sts.find_done && used_reg[cur_reg] && mtype[cur_reg] == TYPE_SMALL;
        sts.find_stop = !sts.find_done && used_reg[cur_reg] && mtype[cur_reg] == TYPE_STOP;
        sts.deliv_done = walk_end_reg && used_reg[cur_reg] && cur_reg == stop_reg;
        sts.deliv_any = (n_reg != '0) ||
            (used_reg[cur_reg] && msrc[cur_reg] == src_reg && pos_reg < {1'b0, lim_reg});
        sts.clr_done = cnt_reg[QW];
    end

    always_ff @(posedge clk)
    begin
        rd_reg <= pay_mem[cur_reg];
        if (ctl.frame_dec && !filt_hit && !full)
            pay_mem[ins_reg] <= pay_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            for (int i = 0; i < FILTER_SLOTS; i++) fslot_reg[i] <= '0;
            ins_reg <= '0; con_reg <= '0; cur_reg <= '0; stop_reg <= '0;
            cnt_reg <= '0; fidx_reg <= '0; fhit_reg <= 1'b0; ffree_reg <= 1'b0;
            fpos_reg <= '0; cmd_reg <= '0; n_reg <= '0; pos_reg <= '0;
            done_reg <= 1'b0; walk_end_reg <= 1'b0; small_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.cap)
            begin
                cmd_reg <= command; typ_reg <= frame_type; src_reg <= frame_source;
                len_reg <= (frame_length > 4'd8) ? 4'd8 : frame_length;
                pay_reg <= frame_payload; drop_reg <= filter_drop;
                lim_reg <= read_limit;
                fidx_reg <= '0; fhit_reg <= 1'b0; ffree_reg <= 1'b0;
                cnt_reg <= '0;
                if (command == CMD_CLEAR || command == CMD_FRAME ||
                    command == CMD_READ)
                    ; // handled in following states
            end
            if (ctl.deliv_init)
            begin
                cur_reg <= con_reg; n_reg <= '0; pos_reg <= '0;
                if (cmd_reg != CMD_FRAME && cmd_reg != CMD_READ && cmd_reg != CMD_CLEAR)
                    done_reg <= 1'b0;
            end
            if (ctl.fscan && !sts.fscan_done)
            begin
                if (typ_reg == TYPE_START)
                begin
                    if (fslot_reg[fpos_cur] == 9'd0)
                    begin
                        ffree_reg <= 1'b1; fpos_reg <= fpos_cur;
                    end
                end
                else if (fslot_reg[fpos_cur] == {1'b0, src_reg} + 9'd1)
                begin
                    fhit_reg <= 1'b1; fpos_reg <= fpos_cur;
                end
                if (!((typ_reg == TYPE_START) ? fslot_reg[fpos_cur] == 9'd0
                      : fslot_reg[fpos_cur] == {1'b0, src_reg} + 9'd1))
                    fidx_reg <= fidx_reg + 1'b1;
            end
            if (ctl.frame_dec)
            begin
                done_reg <= !sts.frame_to_rel;
                st_reg <= filt_hit ? ST_FILTERED : (full ? ST_FULL : ST_STORED);
                ps_reg <= '0; cd_reg <= '0; cc_reg <= '0; last_reg <= 1'b1;
                cur_reg <= con_reg;
                if (filt_hit)
                begin
                    if (typ_reg == TYPE_START && drop_reg)
                        fslot_reg[fpos_reg] <= {1'b0, src_reg} + 9'd1;
                    else if (typ_reg == TYPE_STOP)
                        fslot_reg[fpos_reg] <= '0;
                end
                else if (!full)
                begin
                    used_reg[ins_reg] <= 1'b1;
                    mtype[ins_reg] <= typ_reg; msrc[ins_reg] <= src_reg;
                    mlen[ins_reg] <= len_reg;
                    ins_reg <= ins_reg + 1'b1;
                end
            end
            if (ctl.rel_step && cur_reg != ins_reg)
            begin
                if (msrc[cur_reg] == src_reg) used_reg[cur_reg] <= 1'b0;
                cur_reg <= cur_nx;
            end
            if (ctl.skip_step)
            begin
                if (!sts.skip_done) con_reg <= con_reg + 1'b1;
                else if (cmd_reg == CMD_FRAME) done_reg <= 1'b1;
            end
            if (ctl.find_step)
            begin
                if (sts.find_stop)
                begin
                    stop_reg <= cur_reg; src_reg <= msrc[cur_reg]; cur_reg <= con_reg;
                end
                else if (sts.find_small)
                    small_reg <= cur_reg;
                else if (!sts.find_done)
                    cur_reg <= cur_nx;
                if (ctl.emit_empty)
                begin
                    done_reg <= 1'b1; st_reg <= ST_EMPTY; ps_reg <= '0;
                    cd_reg <= '0; cc_reg <= '0; last_reg <= 1'b1;
                end
            end
            if (ctl.small_out)
            begin
                done_reg <= 1'b1; st_reg <= ST_CHUNK; ps_reg <= msrc[small_reg];
                cc_reg <= ({6'd0, mlen[small_reg]} < lim_reg) ? mlen[small_reg] : lim_reg[3:0];
                cd_reg <= rd_reg & bmask(({6'd0, mlen[small_reg]} < lim_reg)
                                         ? mlen[small_reg] : lim_reg[3:0]);
                last_reg <= 1'b1;
                used_reg[small_reg] <= 1'b0;
            end
            if (ctl.deliv_step)
            begin
                // two-phase step: payload read registers, then emit
                walk_end_reg <= ~walk_end_reg;
                if (walk_end_reg)
                begin
                    if (used_reg[cur_reg] && msrc[cur_reg] == src_reg)
                    begin
                        if (pos_reg < {1'b0, lim_reg} && n_reg < OW'(MAX_OUT))
                        begin
                            done_reg <= 1'b1; st_reg <= ST_CHUNK; ps_reg <= src_reg;
                            cc_reg <= cchunk; cd_reg <= rd_reg & bmask(cchunk);
                            last_reg <= chunk_last;
                            n_reg <= n_reg + 1'b1;
                            pos_reg <= pos_reg + {7'd0, cchunk};
                        end
                        used_reg[cur_reg] <= 1'b0;
                    end
                    if (!sts.deliv_done) cur_reg <= cur_nx;
                    if (ctl.emit_zero)
                    begin
                        done_reg <= 1'b1; st_reg <= ST_CHUNK; ps_reg <= src_reg;
                        cc_reg <= '0; cd_reg <= '0; last_reg <= 1'b1;
                    end
                end
            end
            if (ctl.clr_step)
            begin
                used_reg <= '0;
                for (int i = 0; i < FILTER_SLOTS; i++) fslot_reg[i] <= '0;
                ins_reg <= '0; con_reg <= '0;
                cnt_reg <= {1'b1, {QW{1'b0}}};
                if (ctl.emit_clear)
                begin
                    done_reg <= 1'b1; st_reg <= ST_STORED; ps_reg <= '0;
                    cd_reg <= '0; cc_reg <= '0; last_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign status = st_reg;
    assign packet_source = ps_reg;
    assign chunk_data = cd_reg;
    assign chunk_count = cc_reg;
    assign last = last_reg;
endmodule
`default_nettype wire

>>> src/can_frame_reassembly_queue.sv
// A small frame skips the filter table scan; other frames first scan the
// filter table, up to FILTER_SLOTS slots. A stop frame that finds the queue
// full releases each queued entry of its source, then skips stale entries.
// A read searches the ring entry by entry, walks its entries with a payload
// read before each emit, then skips stale entries. One command at a time;
// the receiver cannot stall. Reset empties the queue and the filter table.
//------------------------------------------------------------------------------
// can_frame_reassembly_queue: CAN receive reassembly queue
// Ties the sequencing controller to the queue datapath.
//------------------------------------------------------------------------------
`default_nettype none
module can_frame_reassembly_queue
    import cfrq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [1:0]  frame_type,
    input  wire logic [7:0]  frame_source,
    input  wire logic [3:0]  frame_length,
    input  wire logic [63:0] frame_payload,
    input  wire logic        filter_drop,
    input  wire logic [9:0]  read_limit,
    output logic             done,
    output logic [2:0]       status,
    output logic [7:0]       packet_source,
    output logic [63:0]      chunk_data,
    output logic [3:0]       chunk_count,
    output logic             last
);
    // The controller issues one step command per cycle; the datapath answers
    // with scan status and raises done on every result it registers. Busy
    // stays high until the command's work ends, which can be after its last
    // result, and results appear on done for one cycle each.
    ctl_t ctl;
    sts_t sts;

    cfrq_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ctl(ctl), .sts(sts)
    );

    cfrq_dp u_dp (
        .clk(clk), .rst_n(rst_n), .command(command), .frame_type(frame_type),
        .frame_source(frame_source), .frame_length(frame_length),
        .frame_payload(frame_payload), .filter_drop(filter_drop),
        .read_limit(read_limit), .ctl(ctl), .sts(sts), .done(done),
        .status(status), .packet_source(packet_source), .chunk_data(chunk_data),
        .chunk_count(chunk_count), .last(last)
    );
endmodule
`default_nettype wire

>>> src/cfrq_checker.sv
//------------------------------------------------------------------------------
// cfrq_checker: port-level checks
// Watches the command and result ports of the queue over time.
//------------------------------------------------------------------------------
`default_nettype none
module cfrq_checker
    import cfrq_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       done,
    input wire logic [2:0] status,
    input wire logic [3:0] chunk_count
);
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> chunk_count <= 4'd8) else $error("chunk count too large");
    a_count_only_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_CHUNK |-> chunk_count == 4'd0)
        else $error("count on non-chunk result");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> status <= ST_CHUNK) else $error("bad status");
endmodule

bind can_frame_reassembly_queue cfrq_checker u_cfrq_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .chunk_count(chunk_count)
);
`default_nettype wire
